// ===== hdl/htw_pkg.sv =====
// Shared types and constants for the hashed timer wheel.
// Used by the divider, the entry memory and the top level; no dependencies.
package htw_pkg;

  localparam int TIMEOUT_W = 32;
  localparam int INTV_W    = 12;
  localparam int QUO_W     = 31;
  localparam int ROUNDS_W  = 31;
  localparam int HANDLE_W  = 5;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ADDED    = 2'd0;
  localparam kind_t KIND_REJECTED = 2'd1;
  localparam kind_t KIND_EXPIRED  = 2'd2;
  localparam kind_t KIND_TICKDONE = 2'd3;

endpackage

// ===== hdl/htw_divider.sv =====
// Restoring divider, one quotient bit per cycle; divides the add timeout by the slot interval.
// Depends on htw_pkg.
module htw_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [htw_pkg::QUO_W-1:0]     dividend,
  input  logic [htw_pkg::INTV_W-1:0]    divisor,
  output logic                          done,
  output logic [htw_pkg::QUO_W-1:0]     quotient
);
  import htw_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [QUO_W-1:0]    dvd_r, dvd_nxt;
  logic [INTV_W-1:0]   rem_r, rem_nxt;
  logic [INTV_W-1:0]   dvs_r, dvs_nxt;
  logic [INTV_W:0]     shifted;
  logic                fits;

  assign shifted = {rem_r, dvd_r[QUO_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[QUO_W-2:0], fits};
      rem_nxt = fits ? INTV_W'(shifted - {1'b0, dvs_r}) : INTV_W'(shifted);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== hdl/htw_entry_mem.sv =====
// Timer entry store: slot and rounds per entry, one write and one registered read port.
// Depends on htw_pkg.
module htw_entry_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int SW    = 6
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [SW-1:0]                  wr_slot,
  input  logic [htw_pkg::ROUNDS_W-1:0]   wr_rounds,
  input  logic [AW-1:0]                  rd_addr,
  output logic [SW-1:0]                  rd_slot,
  output logic [htw_pkg::ROUNDS_W-1:0]   rd_rounds
);
  import htw_pkg::*;

  logic [SW+ROUNDS_W-1:0] mem [DEPTH];
  logic [SW+ROUNDS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_slot, wr_rounds};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_slot   = rd_data_r[SW+ROUNDS_W-1:ROUNDS_W];
  assign rd_rounds = rd_data_r[ROUNDS_W-1:0];

endmodule

// ===== hdl/hashed_timer_wheel.sv =====
// Hashed timer wheel top level: sequencer, valid bits and slot pointer.
// Depends on htw_pkg, htw_divider and htw_entry_mem.
// Add: result after the 31-step divider, then rounds, slot and entry write; the next
//   request waits until busy drops. Negative timeout: rejected in the next cycle, busy stays low.
// Tick: tick-done after the scan, one entry per cycle; the next request waits until
//   busy drops. Results cannot be stalled. Sync reset: no timers, slot 0, interval 1.
module hashed_timer_wheel #(
  parameter int SLOTS      = 64,
  parameter int MAX_TIMERS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [htw_pkg::INTV_W-1:0]     cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic signed [htw_pkg::TIMEOUT_W-1:0] in_timeout,
  output logic                           out_valid,
  output htw_pkg::kind_t                 out_kind,
  output logic [htw_pkg::HANDLE_W-1:0]   out_handle,
  output logic                           out_last
);
  import htw_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int RSH = QUO_W + SW;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [QUO_W:0]   RECIP     = RECIP_FULL[QUO_W:0];
  localparam logic [QUO_W-1:0] SLOTS_Q   = QUO_W'(SLOTS);
  localparam logic [CW-1:0]     CNT_END   = CW'(MAX_TIMERS);
  localparam logic [SW-1:0]     SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [SW:0]       SLOT_CNT  = (SW + 1)'(SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_RECIP = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_TDONE = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [INTV_W-1:0]     intv_r, intv_nxt;
  logic [SW-1:0]         cur_r, cur_nxt;
  logic [MAX_TIMERS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]         srch_r, srch_nxt;
  logic                  found_r, found_nxt;
  logic [CW-1:0]         sc_r, sc_nxt;
  logic                  pv_r, pv_nxt;
  logic [IW-1:0]         pidx_r, pidx_nxt;
  logic                  ov_r, ov_nxt;
  kind_t                 okind_r, okind_nxt;
  logic [HANDLE_W-1:0]   ohnd_r, ohnd_nxt;
  logic                  olast_r, olast_nxt;
  logic [QUO_W-1:0]      ticks_r, ticks_nxt;
  logic [SW-1:0]         rem_r, rem_nxt;
  logic [ROUNDS_W-1:0]   rounds_r, rounds_nxt;

  logic                  accept;
  logic                  div_start, div_done;
  logic [QUO_W-1:0]      div_dvd, div_quo;
  logic [INTV_W-1:0]     div_dvs;
  logic [QUO_W-1:0]      ticks;
  logic [2*QUO_W:0]      recip_prod;
  logic [QUO_W-1:0]      rem_full;
  logic [SW:0]           slot_sum;
  logic [SW-1:0]         slot_new;
  logic [IW-1:0]         srch_idx;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [SW-1:0]         mem_wslot, mem_rslot;
  logic [ROUNDS_W-1:0]   mem_wrounds, mem_rrounds;
  logic                  hit;

  assign busy       = state_r != ST_IDLE;
  assign accept     = start && !busy;
  assign srch_idx   = srch_r[IW-1:0];
  assign div_dvd    = in_timeout[QUO_W-1:0];
  assign div_dvs    = (intv_r == '0) ? INTV_W'(1) : intv_r;
  assign ticks      = (div_quo == '0) ? QUO_W'(1) : div_quo;
  assign recip_prod = {{(QUO_W + 1){1'b0}}, ticks_r} * {{(QUO_W - 1){1'b0}}, RECIP};
  assign rem_full   = ticks_r - rounds_r * SLOTS_Q;
  assign slot_sum   = {1'b0, cur_r} + {1'b0, rem_r};
  assign slot_new   = (slot_sum >= SLOT_CNT) ? SW'(slot_sum - SLOT_CNT) : SW'(slot_sum);
  assign hit        = pv_r && valid_r[pidx_r] && (mem_rslot == cur_r);

  htw_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo)
  );

  htw_entry_mem #(
    .DEPTH (MAX_TIMERS),
    .AW    (IW),
    .SW    (SW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_slot   (mem_wslot),
    .wr_rounds (mem_wrounds),
    .rd_addr   (sc_r[IW-1:0]),
    .rd_slot   (mem_rslot),
    .rd_rounds (mem_rrounds)
  );

  always_comb begin
    state_nxt   = state_r;
    intv_nxt    = cfg_we ? cfg_wdata : intv_r;
    cur_nxt     = cur_r;
    valid_nxt   = valid_r;
    srch_nxt    = srch_r;
    found_nxt   = found_r;
    sc_nxt      = sc_r;
    pv_nxt      = 1'b0;
    pidx_nxt    = pidx_r;
    ov_nxt      = 1'b0;
    okind_nxt   = okind_r;
    ohnd_nxt    = '0;
    olast_nxt   = 1'b1;
    ticks_nxt   = ticks_r;
    rem_nxt     = rem_r;
    rounds_nxt  = rounds_r;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pidx_r;
    mem_wslot   = mem_rslot;
    mem_wrounds = mem_rrounds - 1'b1;

    // free-entry search runs alongside the division
    if ((state_r inside {ST_DIV, ST_RECIP, ST_MOD, ST_FIN}) &&
        !found_r && srch_r != CNT_END) begin
      if (!valid_r[srch_idx]) begin
        found_nxt = 1'b1;
      end else begin
        srch_nxt = srch_r + 1'b1;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command) begin
            state_nxt = ST_SCAN;
            sc_nxt    = '0;
          end else if (in_timeout[TIMEOUT_W-1]) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_REJECTED;
          end else begin
            state_nxt = ST_DIV;
            div_start = 1'b1;
            srch_nxt  = '0;
            found_nxt = 1'b0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RECIP;
          ticks_nxt = ticks;
        end
      end
      ST_RECIP: begin
        state_nxt  = ST_MOD;
        rounds_nxt = ROUNDS_W'(recip_prod >> RSH);
      end
      ST_MOD: begin
        state_nxt = ST_FIN;
        rem_nxt   = rem_full[SW-1:0];
      end
      ST_FIN: begin
        if (found_r || srch_r == CNT_END) begin
          state_nxt = ST_IDLE;
          ov_nxt    = 1'b1;
          if (found_r) begin
            okind_nxt           = KIND_ADDED;
            ohnd_nxt            = HANDLE_W'(srch_idx);
            valid_nxt[srch_idx] = 1'b1;
            mem_we              = 1'b1;
            mem_waddr           = srch_idx;
            mem_wslot           = slot_new;
            mem_wrounds         = rounds_r;
          end else begin
            okind_nxt = KIND_REJECTED;
          end
        end
      end
      ST_SCAN: begin
        if (sc_r != CNT_END) begin
          pv_nxt   = 1'b1;
          pidx_nxt = sc_r[IW-1:0];
          sc_nxt   = sc_r + 1'b1;
        end else begin
          state_nxt = ST_TDONE;
        end
        if (hit) begin
          if (mem_rrounds != '0) begin
            mem_we = 1'b1;
          end else begin
            valid_nxt[pidx_r] = 1'b0;
            ov_nxt            = 1'b1;
            okind_nxt         = KIND_EXPIRED;
            ohnd_nxt          = HANDLE_W'(pidx_r);
            olast_nxt         = 1'b0;
          end
        end
      end
      ST_TDONE: begin
        state_nxt = ST_IDLE;
        ov_nxt    = 1'b1;
        okind_nxt = KIND_TICKDONE;
        cur_nxt   = (cur_r == SLOT_LAST) ? '0 : cur_r + 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      intv_r  <= INTV_W'(1);
      cur_r   <= '0;
      valid_r <= '0;
      srch_r  <= '0;
      found_r <= 1'b0;
      sc_r    <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      intv_r  <= intv_nxt;
      cur_r   <= cur_nxt;
      valid_r <= valid_nxt;
      srch_r  <= srch_nxt;
      found_r <= found_nxt;
      sc_r    <= sc_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r   <= pidx_nxt;
    okind_r  <= okind_nxt;
    ohnd_r   <= ohnd_nxt;
    olast_r  <= olast_nxt;
    ticks_r  <= ticks_nxt;
    rem_r    <= rem_nxt;
    rounds_r <= rounds_nxt;
  end

  assign out_valid  = ov_r;
  assign out_kind   = okind_r;
  assign out_handle = ohnd_r;
  assign out_last   = olast_r;

  a_div_in_add: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside an add");

  a_expire_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == KIND_EXPIRED) |-> ($past(state_r) == ST_SCAN && !olast_r))
    else $error("expired result outside a tick scan");

  a_added_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == KIND_ADDED) |-> valid_r[srch_idx])
    else $error("added handle not marked valid");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_r} < SLOT_CNT)
    else $error("slot pointer out of range");

  a_busy_no_result_mid_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_RECIP || state_r == ST_MOD) |-> !ov_r)
    else $error("result during an add in progress");

endmodule

// ===== tb/hashed_timer_wheel_tb.sv =====
// Self-checking bench for hashed_timer_wheel: directed and random add/tick requests,
// each checked against a shadow wheel kept here. Depends on htw_pkg and the RTL.
module hashed_timer_wheel_tb;
  import htw_pkg::*;

  localparam int SLOTS = 64;
  localparam int MAX_TIMERS = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
    logic                 last;
  } wheel_event_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [INTV_W-1:0]           cfg_wdata = '0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        in_command = CMD_ADD;
  logic signed [TIMEOUT_W-1:0] in_timeout = '0;
  logic                        out_valid;
  kind_t                       out_kind;
  logic [HANDLE_W-1:0]         out_handle;
  logic                        out_last;

  // shadow copy of the wheel
  logic [INTV_W-1:0]   shadow_interval = INTV_W'(1);
  logic                shadow_live [MAX_TIMERS] = '{default: 1'b0};
  logic [SLOT_W-1:0]   shadow_slot [MAX_TIMERS];
  logic [ROUNDS_W-1:0] shadow_rounds [MAX_TIMERS];
  logic [SLOT_W-1:0]   shadow_now = '0;

  wheel_event_t wheel_events_q[$];
  int mismatches = 0;
  int stall_cycles = 0;
  bit gaps_on = 1'b1;

  hashed_timer_wheel #(
    .SLOTS(SLOTS),
    .MAX_TIMERS(MAX_TIMERS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_timeout(in_timeout),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_handle(out_handle),
    .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic expect_result(input kind_t exp_kind, input logic [HANDLE_W-1:0] exp_handle,
                               input logic exp_last);
    wheel_event_t ev;
    ev = '{exp_kind, exp_handle, exp_last};
    wheel_events_q.insert(wheel_events_q.size(), ev);
  endtask

  // Apply one accepted request to the shadow wheel and queue the results it causes.
  task automatic wheel_step(input logic cmd, input logic signed [TIMEOUT_W-1:0] tmo);
    int unsigned divisor;
    int unsigned span;
    int unsigned ticks;
    int free_idx;
    free_idx = -1;
    if (cmd == CMD_ADD) begin
      divisor = (shadow_interval == 0) ? 1 : shadow_interval;
      span = tmo;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
        if (!shadow_live[i]) free_idx = i;
      end
      if (tmo < 0 || free_idx < 0) begin
        expect_result(KIND_REJECTED, '0, 1'b1);
      end else begin
        ticks = (span < divisor) ? 1 : span / divisor;
        shadow_live[free_idx] = 1'b1;
        shadow_slot[free_idx] = SLOT_W'((shadow_now + ticks % SLOTS) % SLOTS);
        shadow_rounds[free_idx] = ROUNDS_W'(ticks / SLOTS);
        expect_result(KIND_ADDED, HANDLE_W'(free_idx), 1'b1);
      end
    end else begin
      for (int i = 0; i < MAX_TIMERS; i++) begin
        if (shadow_live[i] && shadow_slot[i] == shadow_now) begin
          if (shadow_rounds[i] != 0) begin
            shadow_rounds[i] = shadow_rounds[i] - 1'b1;
          end else begin
            shadow_live[i] = 1'b0;
            expect_result(KIND_EXPIRED, HANDLE_W'(i), 1'b0);
          end
        end
      end
      expect_result(KIND_TICKDONE, '0, 1'b1);
      shadow_now = SLOT_W'((shadow_now + 1) % SLOTS);
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_request(input logic cmd, input logic signed [TIMEOUT_W-1:0] tmo);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_timeout <= tmo;
    do @(posedge clk); while (busy);
    wheel_step(cmd, tmo);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (busy || wheel_events_q.size() != 0);
  endtask

  task automatic write_interval(input int unsigned value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= INTV_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_interval = INTV_W'(value);
  endtask

  task automatic test_add_and_reject();
    send_request(CMD_ADD, 0);
    send_request(CMD_ADD, 1);
    send_request(CMD_ADD, 2);
    send_request(CMD_ADD, 63);
    send_request(CMD_ADD, 64);
    send_request(CMD_ADD, -1);
    send_request(CMD_ADD, 32'sh8000_0000);
    repeat (3) send_request(CMD_TICK, $urandom);
  endtask

  task automatic test_interval_extremes();
    write_interval(0);  // behaves as 1
    send_request(CMD_ADD, 3);
    write_interval(4095);
    send_request(CMD_ADD, 4094);
    send_request(CMD_ADD, 4095);
    send_request(CMD_ADD, 8190);
    send_request(CMD_ADD, 32'sh7fff_ffff);
    write_interval(3600);
    send_request(CMD_ADD, 7200);
    repeat (3) send_request(CMD_TICK, $urandom);
  endtask

  // Fill the pool past capacity, then tick until the short timers are gone.
  task automatic test_pool_full();
    write_interval(1);
    repeat (36) send_request(CMD_ADD, $urandom_range(1, 40));
    repeat (45) send_request(CMD_TICK, $urandom);
  endtask

  task automatic test_random();
    int unsigned phase_interval [6] = '{7, 100, 3600, 1, 0, 4095};
    int unsigned divisor;
    int pick;
    for (int p = 0; p < 6; p++) begin
      write_interval(phase_interval[p]);
      divisor = (phase_interval[p] == 0) ? 1 : phase_interval[p];
      if (p == 5) gaps_on = 1'b0;
      repeat (30) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_request(CMD_TICK, $urandom);
        end else if (pick < 63) begin
          send_request(CMD_ADD, $urandom | 32'h8000_0000);
        end else if (pick < 65) begin
          send_request(CMD_ADD, $urandom & 32'h7fff_ffff);
        end else begin
          send_request(CMD_ADD,
                       $urandom_range(0, 140) * divisor + $urandom_range(0, divisor - 1));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    wheel_event_t want;
    if (rst_n && out_valid) begin
      if (wheel_events_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: kind %0d handle %0d last %0d at %0t",
                   out_kind, out_handle, out_last, $time);
        mismatches++;
      end else begin
        want = wheel_events_q.pop_front();
        if (want.kind !== out_kind || want.handle !== out_handle ||
            want.last !== out_last) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t: expected kind/handle/last %0d/%0d/%0d, got %0d/%0d/%0d",
                     $time, want.kind, want.handle, want.last,
                     out_kind, out_handle, out_last);
          mismatches++;
        end
      end
    end
  end

  // watchdog: no request and no result accepted for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();
    test_add_and_reject();
    test_interval_extremes();
    test_pool_full();
    test_random();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (wheel_events_q.size() != 0) begin
      $display("%0d expected results never arrived", wheel_events_q.size());
      mismatches += wheel_events_q.size();
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
